### design/assert_macros.svh
// Assertion macros used by the limit monitor top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define CLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/clm_pkg.sv
// Shared types and constants of the limit monitor.
`default_nettype none
package clm_pkg;

    localparam int VALUE_W  = 32;
    localparam int TICK_W   = 16;
    localparam int MARGIN_W = 31;
    localparam int AF_W     = 16;
    localparam int ADDR_W   = 5;
    localparam int QUO_W    = 33;
    localparam int STEP_W   = 6;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_HIGH   = 3'd1;
    localparam logic [2:0] REG_LOW    = 3'd2;
    localparam logic [2:0] REG_HH     = 3'd3;
    localparam logic [2:0] REG_LL     = 3'd4;
    localparam logic [2:0] REG_MARGIN = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_APPROACH  = 2'd1;
    localparam logic [1:0] ST_VIOLATED  = 2'd2;
    localparam logic [1:0] ST_EMERGENCY = 2'd3;

    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

    localparam logic signed [AF_W-1:0] AF_ONE     = 16'sd256;
    localparam logic signed [AF_W-1:0] AF_NEG_ONE = -16'sd256;
    localparam logic [AF_W-1:0]        AF_CAP     = 16'd2560;
    localparam logic [AF_W-1:0]        AF_FLOOR   = 16'h8000;

    typedef struct packed {
        logic                        enable;
        logic signed [VALUE_W-1:0]   high;
        logic signed [VALUE_W-1:0]   low;
        logic signed [VALUE_W-1:0]   high_high;
        logic signed [VALUE_W-1:0]   low_low;
        logic [MARGIN_W-1:0]         margin;
    } t_cfg;

    typedef struct packed {
        logic       hon;
        logic       lon;
        logic       hv;
        logic       lv;
        logic       viol;
        logic       appr;
        logic [1:0] status;
    } t_eval;

    typedef struct packed {
        logic               start;
        logic [31:0]        rem;
        logic [QUO_W-1:0]   quo;
        logic [STEP_W-1:0]  steps;
        logic [31:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

### design/constraint_limit_monitor.sv
// Hi / lo / hi-hi / lo-lo limit monitor: top level and sequencer.
// Usage:
//  Input channel (i_in_valid / o_in_ready) carries one request per beat:
//  a new Q16.16 sample with its tick interval, or a clear of the
//  accumulated violation time. Output channel (o_out_valid / i_out_ready)
//  returns one result beat per request: status, flags, Q8.8 approach
//  factor, Q16.16 rate per tick and violation ticks.
//  Limits, margin and enable sit in an APB register file; write them only
//  while no request is in flight.
//  One shared restoring divider does the divisions: 33 steps for the rate
//  (sample with nonzero interval) and 16 steps for each of the high and low
//  approach factors (enabled, active limit, nonzero margin, no saturation). One request at a time.
//  The next request is taken as soon as the result sits in the output
//  register; if the receiver stalls, the next result waits in the
//  sequencer until the output register frees up.
//  Reset (synchronous, active low) clears last value, rate, violation time
//  and output valid, and loads the limits with their "no limit" values.
`default_nettype none
module constraint_limit_monitor (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [clm_pkg::ADDR_W-1:0]            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic      [31:0]                           prdata,
    output logic                                       pready,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic                                  i_req_type,
    input  wire logic signed [clm_pkg::VALUE_W-1:0]    i_sample_value,
    input  wire logic [clm_pkg::TICK_W-1:0]            i_interval_ticks,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [1:0]                                 o_status_code,
    output logic                                       o_violating,
    output logic                                       o_approaching,
    output logic signed [clm_pkg::AF_W-1:0]            o_zone_factor,
    output logic signed [clm_pkg::VALUE_W-1:0]         o_change_rate,
    output logic [clm_pkg::VALUE_W-1:0]                o_violation_ticks
);

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_RATE      = 3'd1;
    localparam logic [2:0] S_RATE_WAIT = 3'd2;
    localparam logic [2:0] S_AF        = 3'd3;
    localparam logic [2:0] S_AF_WAIT   = 3'd4;
    localparam logic [2:0] S_FIN       = 3'd5;

    clm_pkg::t_cfg     w_cfg;
    clm_pkg::t_eval    w_eval;
    clm_pkg::t_div_req w_div_req;
    clm_pkg::t_div_rsp w_div_rsp;

    logic [2:0]                            r_state, n_state;
    logic                                  r_clear, n_clear;
    logic                                  r_sel, n_sel;
    logic signed [clm_pkg::VALUE_W-1:0]    r_v, n_v;
    logic signed [clm_pkg::VALUE_W-1:0]    r_last, n_last;
    logic signed [clm_pkg::VALUE_W-1:0]    r_rate, n_rate;
    logic [clm_pkg::VALUE_W-1:0]           r_vt, n_vt;
    logic signed [32:0]                    r_diff, n_diff;
    logic [clm_pkg::TICK_W-1:0]            r_dt, n_dt;
    logic signed [clm_pkg::AF_W-1:0]       r_afh, n_afh, r_afl, n_afl;
    logic                                  r_out_valid, n_out_valid;
    logic [1:0]                            r_st, n_st;
    logic                                  r_viol, n_viol, r_appr, n_appr;
    logic signed [clm_pkg::AF_W-1:0]       r_af, n_af;
    logic signed [clm_pkg::VALUE_W-1:0]    r_orate, n_orate;
    logic [clm_pkg::VALUE_W-1:0]           r_ovt, n_ovt;

    // approach factor operand for the limit picked by r_sel
    logic signed [33:0] w_v34, w_hi34, w_lo34, w_m34, w_x, w_xn;
    logic               w_neg, w_on, w_lim_viol, w_ovf;
    logic [32:0]        w_mag;
    logic [40:0]        w_num;
    logic [32:0]        w_dmag, w_dneg, w_rq, w_rq_neg;
    logic [32:0]        w_vt_sum;
    logic               w_af_store;
    logic [clm_pkg::AF_W-1:0] w_af_val;
    logic signed [clm_pkg::AF_W-1:0] w_af_max;

    function automatic logic [clm_pkg::AF_W-1:0] af_clamp(input logic neg, input logic ovf,
                                                         input logic [15:0] q);
        logic [16:0] nq;
        nq = 17'd0 - {1'b0, q};
        if (neg) begin
            af_clamp = (ovf || q > clm_pkg::AF_FLOOR) ? clm_pkg::AF_FLOOR : nq[15:0];
        end else begin
            af_clamp = (ovf || q > clm_pkg::AF_CAP) ? clm_pkg::AF_CAP : q;
        end
    endfunction

    clm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    clm_eval u_eval (
        .i_cfg   (w_cfg),
        .i_value (r_v),
        .o_eval  (w_eval)
    );

    clm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        w_v34  = 34'(r_v);
        w_hi34 = 34'(w_cfg.high);
        w_lo34 = 34'(w_cfg.low);
        w_m34  = $signed({3'b0, w_cfg.margin});
        w_x    = r_sel ? (w_lo34 + w_m34 - w_v34) : (w_v34 - w_hi34 + w_m34);
        w_xn   = -w_x;
        w_neg  = w_x[33];
        w_mag  = w_neg ? w_xn[32:0] : w_x[32:0];
        w_num  = {w_mag, 8'b0};
        // quotient >= 65536 saturates either way
        w_ovf  = {6'b0, w_num[40:16]} >= w_cfg.margin;
        w_on       = r_sel ? w_eval.lon : w_eval.hon;
        w_lim_viol = r_sel ? w_eval.lv : w_eval.hv;

        w_dneg   = 33'd0 - r_diff;
        w_dmag   = r_diff[32] ? w_dneg : r_diff;
        w_rq     = w_div_rsp.quo;
        w_rq_neg = 33'd0 - w_rq;
        w_vt_sum = {1'b0, r_vt} + {17'b0, r_dt};
        w_af_max = (r_afh > r_afl) ? r_afh : r_afl;
    end

    always_comb begin
        n_state     = r_state;
        n_clear     = r_clear;
        n_sel       = r_sel;
        n_v         = r_v;
        n_last      = r_last;
        n_rate      = r_rate;
        n_vt        = r_vt;
        n_diff      = r_diff;
        n_dt        = r_dt;
        n_afh       = r_afh;
        n_afl       = r_afl;
        n_out_valid = r_out_valid && !i_out_ready;
        n_st        = r_st;
        n_viol      = r_viol;
        n_appr      = r_appr;
        n_af        = r_af;
        n_orate     = r_orate;
        n_ovt       = r_ovt;
        w_af_store  = 1'b0;
        w_af_val    = '0;

        w_div_req.start   = 1'b0;
        w_div_req.rem     = '0;
        w_div_req.quo     = w_dmag;
        w_div_req.steps   = clm_pkg::STEP_W'(clm_pkg::QUO_W);
        w_div_req.divisor = {16'b0, r_dt};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_clear = i_req_type;
                    if (i_req_type) begin
                        n_v  = r_last;
                        n_dt = '0;
                    end else begin
                        n_v    = i_sample_value;
                        n_last = i_sample_value;
                        n_diff = 33'(i_sample_value) - 33'(r_last);
                        n_dt   = i_interval_ticks;
                    end
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                n_sel = 1'b0;
                if (!r_clear && r_dt != '0) begin
                    w_div_req.start = 1'b1;
                    n_state         = S_RATE_WAIT;
                end else begin
                    n_state = S_AF;
                end
            end
            S_RATE_WAIT: begin
                if (w_div_rsp.done) begin
                    if (!r_diff[32]) begin
                        n_rate = (w_rq > 33'h0_7FFF_FFFF) ? clm_pkg::VMAX : $signed(w_rq[31:0]);
                    end else begin
                        n_rate = (w_rq > 33'h0_8000_0000) ? clm_pkg::VMIN
                                                          : $signed(w_rq_neg[31:0]);
                    end
                    n_state = S_AF;
                end
            end
            S_AF: begin
                if (w_cfg.enable && w_on && w_cfg.margin != '0) begin
                    if (w_ovf) begin
                        w_af_store = 1'b1;
                        w_af_val   = af_clamp(w_neg, 1'b1, 16'd0);
                    end else begin
                        w_div_req.start   = 1'b1;
                        w_div_req.rem     = {7'b0, w_num[40:16]};
                        w_div_req.quo     = {w_num[15:0], 17'b0};
                        w_div_req.steps   = clm_pkg::STEP_W'(16);
                        w_div_req.divisor = {1'b0, w_cfg.margin};
                        n_state           = S_AF_WAIT;
                    end
                end else begin
                    w_af_store = 1'b1;
                    w_af_val   = w_lim_viol ? clm_pkg::AF_ONE : clm_pkg::AF_NEG_ONE;
                end
            end
            S_AF_WAIT: begin
                if (w_div_rsp.done) begin
                    w_af_store = 1'b1;
                    w_af_val   = af_clamp(w_neg, 1'b0, w_rq[15:0]);
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    priority if (r_clear) begin
                        n_vt = '0;
                    end else if (w_eval.viol) begin
                        n_vt = w_vt_sum[32] ? '1 : w_vt_sum[31:0];
                    end else begin
                        n_vt = r_vt;
                    end
                    n_out_valid = 1'b1;
                    n_st        = w_eval.status;
                    n_viol      = w_eval.viol;
                    n_appr      = w_eval.appr;
                    n_af        = w_cfg.enable ? w_af_max : clm_pkg::AF_NEG_ONE;
                    n_orate     = r_rate;
                    n_ovt       = n_vt;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // factor done for this limit: store it, then low limit or finish
        if (w_af_store) begin
            if (r_sel) begin
                n_afl   = $signed(w_af_val);
                n_state = S_FIN;
            end else begin
                n_afh   = $signed(w_af_val);
                n_sel   = 1'b1;
                n_state = S_AF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_rate      <= '0;
            r_vt        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            r_rate      <= n_rate;
            r_vt        <= n_vt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clear <= n_clear;
        r_sel   <= n_sel;
        r_v     <= n_v;
        r_diff  <= n_diff;
        r_dt    <= n_dt;
        r_afh   <= n_afh;
        r_afl   <= n_afl;
        r_st    <= n_st;
        r_viol  <= n_viol;
        r_appr  <= n_appr;
        r_af    <= n_af;
        r_orate <= n_orate;
        r_ovt   <= n_ovt;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status_code     = r_st;
    assign o_violating       = r_viol;
    assign o_approaching     = r_appr;
    assign o_zone_factor     = r_af;
    assign o_change_rate     = r_orate;
    assign o_violation_ticks = r_ovt;

    `CLM_ASSERT(a_busy_not_ready, w_div_rsp.busy |-> !o_in_ready, "divider busy while ready")
    `CLM_ASSERT(a_one_in_flight, (i_in_valid && o_in_ready) |=> !o_in_ready, "second beat taken")
    `CLM_ASSERT(a_flags_match, o_out_valid |-> ((o_violating == o_status_code[1]) && !(o_violating && o_approaching)), "status and flags disagree")
    `CLM_ASSERT(a_af_cap, o_out_valid |-> (o_zone_factor <= $signed(clm_pkg::AF_CAP)), "approach factor above cap")
    `CLM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_out_valid && o_in_ready), "not idle after reset")

endmodule
`default_nettype wire

### design/clm_cfg.sv
// APB register file holding the limit monitor configuration.
`default_nettype none
module clm_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [clm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output clm_pkg::t_cfg                      o_cfg
);

    clm_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable    <= 1'b0;
            r_cfg.high      <= clm_pkg::VMAX;
            r_cfg.low       <= clm_pkg::VMIN;
            r_cfg.high_high <= clm_pkg::VMAX;
            r_cfg.low_low   <= clm_pkg::VMIN;
            r_cfg.margin    <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                clm_pkg::REG_ENABLE: r_cfg.enable    <= pwdata[0];
                clm_pkg::REG_HIGH:   r_cfg.high      <= $signed(pwdata);
                clm_pkg::REG_LOW:    r_cfg.low       <= $signed(pwdata);
                clm_pkg::REG_HH:     r_cfg.high_high <= $signed(pwdata);
                clm_pkg::REG_LL:     r_cfg.low_low   <= $signed(pwdata);
                clm_pkg::REG_MARGIN: r_cfg.margin    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            clm_pkg::REG_ENABLE: prdata = {31'b0, r_cfg.enable};
            clm_pkg::REG_HIGH:   prdata = r_cfg.high;
            clm_pkg::REG_LOW:    prdata = r_cfg.low;
            clm_pkg::REG_HH:     prdata = r_cfg.high_high;
            clm_pkg::REG_LL:     prdata = r_cfg.low_low;
            clm_pkg::REG_MARGIN: prdata = {1'b0, r_cfg.margin};
            default:             prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### design/clm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module clm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire clm_pkg::t_div_req i_req,
    output clm_pkg::t_div_rsp      o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [31:0]                 r_rem;
    logic [clm_pkg::QUO_W-1:0]   r_quo;
    logic [31:0]                 r_div;
    logic [clm_pkg::STEP_W-1:0]  r_cnt;

    logic [32:0] w_trial;
    logic [32:0] w_sub;
    logic        w_ge;

    // shift in the next dividend bit, subtract when it fits
    assign w_trial = {r_rem, r_quo[clm_pkg::QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_sub   = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == clm_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_quo <= i_req.quo;
            r_div <= i_req.divisor;
            r_cnt <= i_req.steps;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[31:0] : w_trial[31:0];
            r_quo <= {r_quo[clm_pkg::QUO_W-2:0], w_ge};
            r_cnt <= r_cnt - clm_pkg::STEP_W'(1);
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

### design/clm_eval.sv
// Limit compares: emergency, violation and approach flags and status.
`default_nettype none
module clm_eval (
    input  wire clm_pkg::t_cfg                    i_cfg,
    input  wire logic signed [clm_pkg::VALUE_W-1:0] i_value,
    output clm_pkg::t_eval                        o_eval
);

    logic signed [33:0] w_v, w_hi, w_lo, w_m;
    logic               w_hon, w_lon, w_emerg, w_hv, w_lv, w_ha, w_la, w_viol, w_appr;

    always_comb begin
        w_v  = 34'(i_value);
        w_hi = 34'(i_cfg.high);
        w_lo = 34'(i_cfg.low);
        w_m  = $signed({3'b0, i_cfg.margin});

        w_hon   = i_cfg.high != clm_pkg::VMAX;
        w_lon   = i_cfg.low != clm_pkg::VMIN;
        w_emerg = (i_cfg.high_high != clm_pkg::VMAX && i_value >= i_cfg.high_high) ||
                  (i_cfg.low_low != clm_pkg::VMIN && i_value <= i_cfg.low_low);
        w_hv    = w_hon && i_value >= i_cfg.high;
        w_lv    = w_lon && i_value <= i_cfg.low;
        w_ha    = w_hon && !w_hv && w_v >= (w_hi - w_m);
        w_la    = w_lon && !w_lv && w_v <= (w_lo + w_m);
        w_viol  = i_cfg.enable && (w_emerg || w_hv || w_lv);
        w_appr  = i_cfg.enable && !w_viol && (w_ha || w_la);

        o_eval.hon  = w_hon;
        o_eval.lon  = w_lon;
        o_eval.hv   = i_cfg.enable && w_hv;
        o_eval.lv   = i_cfg.enable && w_lv;
        o_eval.viol = w_viol;
        o_eval.appr = w_appr;
        priority if (!i_cfg.enable) begin
            o_eval.status = clm_pkg::ST_OK;
        end else if (w_emerg) begin
            o_eval.status = clm_pkg::ST_EMERGENCY;
        end else if (w_hv || w_lv) begin
            o_eval.status = clm_pkg::ST_VIOLATED;
        end else if (w_appr) begin
            o_eval.status = clm_pkg::ST_APPROACH;
        end else begin
            o_eval.status = clm_pkg::ST_OK;
        end
    end

endmodule
`default_nettype wire
